>>> rtl/core/sac_pkg.sv
// Shared types and constants for the size class reuse allocator.
`default_nettype none
package sac_pkg;

  localparam int DEF_ADDR_BITS       = 20;
  localparam int DEF_NUM_CLASSES     = 16;
  localparam int DEF_SLOTS_PER_CLASS = 16;

  // request type codes
  localparam logic [1:0] REQ_PROBE = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // command broadcast to the class cells
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_POP    = 2'd1,
    OP_PUSH   = 2'd2,
    OP_INSERT = 2'd3
  } cell_op_t;

endpackage
`default_nettype wire

>>> rtl/core/sac_cell.sv
// One size class cell: size, fill level and stack bank, shifts right on insert.
`default_nettype none
module sac_cell import sac_pkg::*; #(
  parameter int SZW = 21,
  parameter int FW  = 5,
  parameter int BW  = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [SZW-1:0] req_size,
  input  wire cell_op_t       cmd_op,
  input  wire logic [BW-1:0]  cmd_bank,
  input  wire logic           pass_in,
  input  wire logic           prev_valid,
  input  wire logic [SZW-1:0] left_size,
  input  wire logic [FW-1:0]  left_fill,
  input  wire logic [BW-1:0]  left_bank,
  output logic                pass_out,
  output logic                valid,
  output logic                hit,
  output logic [SZW-1:0]      size,
  output logic [FW-1:0]       fill,
  output logic [BW-1:0]       bank
);

  logic           valid_r, valid_nxt;
  logic [SZW-1:0] size_r, size_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [BW-1:0]  bank_r, bank_nxt;
  logic           ge;

  assign ge       = size_r >= req_size;
  assign pass_out = valid_r && ge;
  assign hit      = !pass_in && prev_valid && (!valid_r || ge);
  assign valid    = valid_r;
  assign size     = size_r;
  assign fill     = fill_r;
  assign bank     = bank_r;

  always_comb begin
    valid_nxt = valid_r;
    size_nxt  = size_r;
    fill_nxt  = fill_r;
    bank_nxt  = bank_r;
    case (cmd_op)
      OP_INSERT: begin
        if (pass_in) begin
          valid_nxt = 1'b1;
          size_nxt  = left_size;
          fill_nxt  = left_fill;
          bank_nxt  = left_bank;
        end else if (hit) begin
          valid_nxt = 1'b1;
          size_nxt  = req_size;
          fill_nxt  = FW'(1);
          bank_nxt  = cmd_bank;
        end
      end
      OP_PUSH: if (hit) fill_nxt = fill_r + FW'(1);
      OP_POP:  if (hit) fill_nxt = fill_r - FW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fill_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
    end
    size_r <= size_nxt;
    bank_r <= bank_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/size_class_reuse_allocator.sv
// Top level of the size class reuse allocator: cell chain, stack memory, control.
//
// Handles probe, alloc and free requests against a bump pointer and a sorted
// table of size classes, each with a LIFO stack of freed offsets. The classes
// sit in a chain of cells in ascending size order; every cell compares its size
// against the request, and the first cell at or above it is the chosen class.
// A new class is inserted in place by shifting the upper cells right by one. Each
// class owns a fixed bank of the stack memory (assigned in creation order), so
// only size, fill level and bank number move on insert. Every request passes
// through capture, class lookup, update with stack memory read or write, and
// result. One request is in flight at a time; the next input transfer is taken
// once the result register is loaded, while the result may still wait for its
// transfer. A free into a full stack, or of a new size with the table full, is
// dropped and flagged.
// The user must write max_capacity through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module size_class_reuse_allocator import sac_pkg::*; #(
  parameter int ADDR_BITS       = DEF_ADDR_BITS,
  parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
  parameter int SLOTS_PER_CLASS = DEF_SLOTS_PER_CLASS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [ADDR_BITS:0]   cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_req_type,
  input  wire logic [ADDR_BITS:0]   in_req_size,
  input  wire logic [ADDR_BITS-1:0] in_block_offset,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_ok,
  output logic [ADDR_BITS-1:0]      out_grant_offset,
  output logic [ADDR_BITS:0]        out_grant_size,
  output logic [ADDR_BITS:0]        out_used_total,
  output logic                      out_free_dropped
);

  localparam int SZW   = ADDR_BITS + 1;
  localparam int FW    = $clog2(SLOTS_PER_CLASS + 1);
  localparam int BW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CW    = $clog2(NUM_CLASSES + 1);
  localparam int DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SZW:0] SPAN = (SZW + 1)'(1) << ADDR_BITS;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_DONE} state_t;

  state_t state_r, state_nxt;

  // captured request and configuration
  logic [1:0]           type_r;
  logic [SZW-1:0]       req_r;
  logic [ADDR_BITS-1:0] ofs_r;
  logic [SZW-1:0]       cap_r;
  logic [SZW-1:0]       bump_r;
  logic [CW-1:0]        count_r;

  // chain wiring
  logic [NUM_CLASSES:0]   pass_w;
  logic [NUM_CLASSES:0]   pvalid_w;
  logic [SZW-1:0]         csize_w [NUM_CLASSES];
  logic [FW-1:0]          cfill_w [NUM_CLASSES];
  logic [BW-1:0]          cbank_w [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] cvalid_w;
  logic [NUM_CLASSES-1:0] chit_w;
  cell_op_t               cmd_op;

  // selected class, registered in the lookup cycle
  logic           sel_valid_r;
  logic [SZW-1:0] sel_size_r;
  logic [FW-1:0]  sel_fill_r;
  logic [BW-1:0]  sel_bank_r;
  logic           sel_valid_c;
  logic [SZW-1:0] sel_size_c;
  logic [FW-1:0]  sel_fill_c;
  logic [BW-1:0]  sel_bank_c;

  // result staging
  logic                 res_ok_r, res_drop_r, res_pop_r;
  logic [ADDR_BITS-1:0] res_ofs_r;
  logic [SZW-1:0]       res_size_r;
  logic                 res_ok_c, res_drop_c, res_pop_c;
  logic [ADDR_BITS-1:0] res_ofs_c;
  logic [SZW-1:0]       res_size_c;

  // stack memory
  logic [ADDR_BITS-1:0] stack_mem [DEPTH];
  logic [ADDR_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr;

  // output register
  logic                 out_valid_r, out_ok_r, out_drop_r;
  logic [ADDR_BITS-1:0] out_ofs_r;
  logic [SZW-1:0]       out_size_r, out_used_r;

  // decision terms
  logic           is_pa, req_nz, fit_ok, bump_ok, reuse, exact, full;
  logic [SZW+2:0] req_x5, size_x4;
  logic [SZW:0]   bump_end;
  logic           out_free;

  assign pass_w[0]   = 1'b0;
  assign pvalid_w[0] = 1'b1;

  for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
    logic [SZW-1:0] lsize;
    logic [FW-1:0]  lfill;
    logic [BW-1:0]  lbank;
    if (i == 0) begin : g_first
      assign lsize = '0;
      assign lfill = '0;
      assign lbank = '0;
    end else begin : g_rest
      assign lsize = csize_w[i-1];
      assign lfill = cfill_w[i-1];
      assign lbank = cbank_w[i-1];
    end
    sac_cell #(.SZW(SZW), .FW(FW), .BW(BW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req_size   (req_r),
      .cmd_op     (cmd_op),
      .cmd_bank   (count_r[BW-1:0]),
      .pass_in    (pass_w[i]),
      .prev_valid (pvalid_w[i]),
      .left_size  (lsize),
      .left_fill  (lfill),
      .left_bank  (lbank),
      .pass_out   (pass_w[i+1]),
      .valid      (cvalid_w[i]),
      .hit        (chit_w[i]),
      .size       (csize_w[i]),
      .fill       (cfill_w[i]),
      .bank       (cbank_w[i])
    );
    assign pvalid_w[i+1] = cvalid_w[i];
  end

  // gather the one cell that hit
  always_comb begin
    sel_valid_c = 1'b0;
    sel_size_c  = '0;
    sel_fill_c  = '0;
    sel_bank_c  = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (chit_w[i]) begin
        sel_valid_c = sel_valid_c | cvalid_w[i];
        sel_size_c  = sel_size_c | csize_w[i];
        sel_fill_c  = sel_fill_c | cfill_w[i];
        sel_bank_c  = sel_bank_c | cbank_w[i];
      end
    end
  end

  // decision, from registered lookup
  assign is_pa    = (type_r == REQ_PROBE) || (type_r == REQ_ALLOC);
  assign req_nz   = req_r != '0;
  assign req_x5   = ((SZW + 3)'(req_r) << 2) + (SZW + 3)'(req_r);
  assign size_x4  = (SZW + 3)'(sel_size_r) << 2;
  assign fit_ok   = req_x5 > size_x4;
  assign reuse    = req_nz && sel_valid_r && (sel_fill_r != '0) && fit_ok;
  assign bump_end = {1'b0, bump_r} + {1'b0, req_r};
  assign bump_ok  = req_nz && (bump_end <= SPAN) &&
                    ((cap_r == '0) || (bump_end <= {1'b0, cap_r}));
  assign exact    = sel_valid_r && (sel_size_r == req_r);
  assign full     = count_r == CW'(NUM_CLASSES);

  always_comb begin
    cmd_op   = OP_NONE;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = AW'(sel_bank_r) * AW'(SLOTS_PER_CLASS) + AW'(sel_fill_r);
    if (state_r == S_EXEC) begin
      if (is_pa && reuse) begin
        if (type_r == REQ_ALLOC) begin
          cmd_op   = OP_POP;
          mem_re   = 1'b1;
          mem_addr = AW'(sel_bank_r) * AW'(SLOTS_PER_CLASS) + AW'(sel_fill_r - FW'(1));
        end
      end else if (type_r == REQ_FREE) begin
        if (exact) begin
          if (sel_fill_r < FW'(SLOTS_PER_CLASS)) begin
            cmd_op = OP_PUSH;
            mem_we = 1'b1;
          end
        end else if (!full) begin
          cmd_op   = OP_INSERT;
          mem_we   = 1'b1;
          mem_addr = AW'(count_r[BW-1:0]) * AW'(SLOTS_PER_CLASS);
        end
      end
    end
  end

  // result of the update cycle, staged for the result register
  always_comb begin
    res_ok_c   = 1'b0;
    res_drop_c = 1'b0;
    res_pop_c  = 1'b0;
    res_ofs_c  = '0;
    res_size_c = '0;
    if (is_pa) begin
      if (reuse) begin
        res_ok_c = 1'b1;
        if (type_r == REQ_ALLOC) begin
          res_pop_c  = 1'b1;
          res_size_c = req_r;
        end
      end else if (bump_ok) begin
        res_ok_c = 1'b1;
        if (type_r == REQ_ALLOC) begin
          res_ofs_c  = bump_r[ADDR_BITS-1:0];
          res_size_c = req_r;
        end
      end
    end else if (type_r == REQ_FREE) begin
      res_ok_c   = mem_we;
      res_drop_c = !mem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_addr] <= ofs_r;
    if (mem_re) rd_data_r <= stack_mem[mem_addr];
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= '0;
      bump_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      // load a new result, or drop the old one once it has transferred
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_EXEC) begin
        if (cmd_op == OP_INSERT) count_r <= count_r + CW'(1);
        if (is_pa && !reuse && bump_ok && (type_r == REQ_ALLOC)) begin
          bump_r <= bump_end[SZW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      type_r <= in_req_type;
      req_r  <= in_req_size;
      ofs_r  <= in_block_offset;
    end
    if (state_r == S_LOOK) begin
      sel_valid_r <= sel_valid_c;
      sel_size_r  <= sel_size_c;
      sel_fill_r  <= sel_fill_c;
      sel_bank_r  <= sel_bank_c;
    end
    if (state_r == S_EXEC) begin
      res_ok_r   <= res_ok_c;
      res_drop_r <= res_drop_c;
      res_pop_r  <= res_pop_c;
      res_ofs_r  <= res_ofs_c;
      res_size_r <= res_size_c;
    end
    if (state_r == S_DONE && out_free) begin
      out_ok_r   <= res_ok_r;
      out_drop_r <= res_drop_r;
      out_ofs_r  <= res_pop_r ? rd_data_r : res_ofs_r;
      out_size_r <= res_size_r;
      out_used_r <= bump_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_grant_offset = out_ofs_r;
  assign out_grant_size   = out_size_r;
  assign out_used_total   = out_used_r;
  assign out_free_dropped = out_drop_r;

endmodule
`default_nettype wire

>>> rtl/core/sac_checker.sv
// Port-level checks for the size class reuse allocator, bound to the top level.
`default_nettype none
module sac_checker #(
  parameter int ADDR_BITS = 20
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_ok,
  input wire logic [ADDR_BITS-1:0] out_grant_offset,
  input wire logic [ADDR_BITS:0]   out_grant_size,
  input wire logic                 out_free_dropped
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_drop_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_free_dropped |-> !out_ok)
    else $error("dropped free reported ok");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_grant_offset == '0) && (out_grant_size == '0))
    else $error("failed request carries a grant");

  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one in flight");

endmodule

bind size_class_reuse_allocator sac_checker #(.ADDR_BITS(ADDR_BITS)) u_sac_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_ok           (out_ok),
  .out_grant_offset (out_grant_offset),
  .out_grant_size   (out_grant_size),
  .out_free_dropped (out_free_dropped)
);
`default_nettype wire
